// File: hw/rtl/mrm_pkg.sv
package mrm_pkg;

    localparam int unsigned CountBits  = 31;
    localparam int unsigned TagBits    = 31;
    localparam int unsigned SizeBits   = 8;
    localparam int unsigned HandleBits = 8;
    localparam int unsigned SrcPortBits = 8;

    typedef enum logic [1:0] {
        ST_MATCHED = 2'd0,
        ST_QUEUED  = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLOSED  = 2'd3
    } t_status;

    typedef enum logic {
        MODE_HEADER = 1'b0,
        MODE_POST   = 1'b1
    } t_mode;

    typedef struct packed {
        logic                  closed;
        logic                  post;
        logic [SrcPortBits-1:0] src;
        logic [CountBits-1:0]  cnt;
        logic [TagBits-1:0]    tag;
        logic [SizeBits-1:0]   size;
        logic [HandleBits-1:0] handle;
    } t_cmd;

endpackage

// File: hw/rtl/message_receive_matcher_top.sv
// An accepted beat is held in the front queue, then registered into the compare stage, and then raises o_done.
// The back end takes no new beat until the previous one has finished its compare and update steps.
// The front queue holds two beats; busy rises only while both are waiting.
// Reset (i_rst_n low, synchronous) empties both match queues and the front queue.
// Results are strobed for one cycle on o_done; the receiver cannot stall.
module message_receive_matcher_top
    import mrm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int RANK_BITS   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_mode,
    input  logic [SrcPortBits-1:0] i_source_rank,
    input  logic [CountBits-1:0]   i_element_count,
    input  logic [TagBits-1:0]     i_message_tag,
    input  logic [SizeBits-1:0]    i_element_size,
    input  logic [HandleBits-1:0]  i_buffer_handle,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [HandleBits-1:0]  o_matched_handle,
    output logic [SrcPortBits-1:0] o_peer_rank
);
    logic w_cmd_valid, w_cmd_pop;
    t_cmd w_cmd;

    // front: accept and classify beats, mask the rank, hold them in a short queue
    mrm_front #(.RANK_BITS(RANK_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_start(start), .o_busy(busy),
        .i_mode, .i_source_rank, .i_element_count, .i_message_tag,
        .i_element_size, .i_buffer_handle,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_cmd_pop)
    );

    // back: search, collapse or append, report
    mrm_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_pop(w_cmd_pop),
        .o_done, .o_status, .o_matched_handle, .o_peer_rank
    );
endmodule

// File: hw/rtl/mrm_front.sv
module mrm_front
    import mrm_pkg::*;
#(
    parameter int RANK_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_mode,
    input  logic [SrcPortBits-1:0] i_source_rank,
    input  logic [CountBits-1:0]   i_element_count,
    input  logic [TagBits-1:0]     i_message_tag,
    input  logic [SizeBits-1:0]    i_element_size,
    input  logic [HandleBits-1:0]  i_buffer_handle,
    output logic                   o_cmd_valid,
    output t_cmd                   o_cmd,
    input  logic                   i_cmd_pop
);
    // two-entry queue toward the back end
    t_cmd r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    t_cmd       w_cmd;
    logic       w_push;

    localparam logic [SrcPortBits-1:0] RankMask =
        SrcPortBits'((1 << RANK_BITS) - 1);

    always_comb begin
        w_cmd.closed = (t_mode'(i_mode) == MODE_HEADER) && (i_element_size == '0);
        w_cmd.post   = (t_mode'(i_mode) == MODE_POST);
        w_cmd.src    = i_source_rank & RankMask;
        w_cmd.cnt    = i_element_count;
        w_cmd.tag    = i_message_tag;
        w_cmd.size   = i_element_size;
        w_cmd.handle = i_buffer_handle;
    end

    assign o_busy      = (r_cnt == 2'd2);
    assign w_push      = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign n_cnt = r_cnt + 2'(w_push) - 2'(i_cmd_pop && o_cmd_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= !r_wr;
            if (i_cmd_pop && o_cmd_valid) r_rd <= !r_rd;
        end
        if (w_push) r_q[r_wr] <= w_cmd;
    end
endmodule

// File: hw/rtl/mrm_back.sv
module mrm_back
    import mrm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [HandleBits-1:0]  o_matched_handle,
    output logic [SrcPortBits-1:0] o_peer_rank
);
    // src arrives already masked to the rank width by the front end
    typedef struct packed {
        logic [SrcPortBits-1:0] src;
        logic [CountBits-1:0]  cnt;
        logic [TagBits-1:0]    tag;
        logic [SizeBits-1:0]   size;
        logic [HandleBits-1:0] handle;
    } t_ent;

    // index 0: posted, 1: unexpected; entries packed from cell 0 up
    t_ent r_e [2][QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_v [2];

    // stage 1: compare across all cells of the search queue, register hits
    logic                   r_act;
    t_cmd                   r_cmd;
    logic [QUEUE_DEPTH-1:0] r_hit;
    logic [QUEUE_DEPTH-1:0] w_hit;
    logic                   w_sq;

    assign w_sq      = i_cmd.post;  // post searches unexpected
    assign o_cmd_pop = i_cmd_valid && !r_act;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_hit[i] = r_v[w_sq][i]
                && (r_e[w_sq][i].src == i_cmd.src)
                && (r_e[w_sq][i].cnt == i_cmd.cnt)
                && (r_e[w_sq][i].tag == i_cmd.tag)
                && (r_e[w_sq][i].size == i_cmd.size);
        end
    end

    // stage 2: pick oldest hit, collapse or append
    logic [QUEUE_DEPTH-1:0] w_first, w_below, w_slot;
    logic                   w_any, w_sq2, w_aq2, w_full;
    logic [HandleBits-1:0]  w_hh;
    t_ent                   w_new;

    always_comb begin
        w_first = r_hit & (~r_hit + 1'b1);
        w_below = w_first - 1'b1;
        w_any   = |r_hit;
        w_sq2   = r_cmd.post;
        w_aq2   = !r_cmd.post;
        w_full  = r_v[w_aq2][QUEUE_DEPTH-1];
        // first free cell of the append queue
        w_slot  = ~r_v[w_aq2] & {r_v[w_aq2][QUEUE_DEPTH-2:0], 1'b1};
        w_hh    = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (w_first[i]) w_hh = r_e[w_sq2][i].handle;
        w_new.src    = r_cmd.src;
        w_new.cnt    = r_cmd.cnt;
        w_new.tag    = r_cmd.tag;
        w_new.size   = r_cmd.size;
        w_new.handle = r_cmd.handle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            o_done <= 1'b0;
            r_v[0] <= '0;
            r_v[1] <= '0;
        end else begin
            r_act  <= o_cmd_pop;
            o_done <= r_act;
            if (r_act && !r_cmd.closed) begin
                if (w_any) begin
                    // drop matched cell, shift younger down
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                        if (!w_below[i]) r_v[w_sq2][i] <= r_v[w_sq2][i+1];
                    r_v[w_sq2][QUEUE_DEPTH-1] <= 1'b0;
                end else if (!w_full) begin
                    r_v[w_aq2] <= {r_v[w_aq2][QUEUE_DEPTH-2:0], 1'b1};
                end
            end
        end
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_hit <= w_hit;
        end
        if (r_act && !r_cmd.closed) begin
            if (w_any) begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    if (!w_below[i]) r_e[w_sq2][i] <= r_e[w_sq2][i+1];
            end else if (!w_full) begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (w_slot[i]) r_e[w_aq2][i] <= w_new;
            end
        end
        if (r_act) begin
            o_peer_rank <= r_cmd.src;
            if (r_cmd.closed) begin
                o_status <= ST_CLOSED;  o_matched_handle <= '0;
            end else if (w_any) begin
                o_status <= ST_MATCHED; o_matched_handle <= w_hh;
            end else if (w_full) begin
                o_status <= ST_FULL;    o_matched_handle <= '0;
            end else begin
                o_status <= ST_QUEUED;  o_matched_handle <= '0;
            end
        end
    end
endmodule
